// ===== hdl/lpa_pkg.sv =====
// lpa_pkg: shared types and constants of the dual stack local preference allocator
// no dependencies; imported by lpa_pref_table and dual_stack_local_pref_allocator_unit
package lpa_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int PREF_W      = 16;
  localparam int RUN_W       = 8;
  localparam int CLASS_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CLS_IDX_W   = 2;

  localparam logic [CLASS_W-1:0] CLASS_NONE  = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_HOST  = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_SRFLX = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_RELAY = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_PRFLX = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_V6_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_V4_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRFLX_V6_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRFLX_V4_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_V6_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_V4_START = 3'd6;

  localparam logic [RUN_W-1:0]  MAX_RUN_RESET = 8'd2;
  localparam logic [PREF_W-1:0] PREF_RESET    = 16'd65535;
  localparam logic [PREF_W-1:0] PREF_STEP     = 16'd20000;

  typedef struct packed {
    logic [CLASS_W-1:0] cand_class;
    logic               is_ipv6;
  } lpa_in_t;

  typedef struct packed {
    logic [PREF_W-1:0] pref_value;
    logic              pref_valid;
  } lpa_out_t;

  typedef struct packed {
    logic                  wen;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } lpa_cfg_t;

  typedef struct packed {
    logic    fire;
    lpa_in_t item;
  } lpa_req_t;

endpackage

// ===== hdl/dual_stack_local_pref_allocator_unit.sv =====
// dual_stack_local_pref_allocator_unit: top level with input and result registers
// depends on lpa_pkg and lpa_pref_table
//
// Usage: each request beat on in_data names a candidate class and an address family
// and yields exactly one result beat on out_data: the granted local preference and
// pref_valid. Host, server reflexive and relay classes interleave IPv6 and IPv4 by
// lowering a family's preference by 20000 once it has max_run grants since the last
// drop in its class. Other classes return 0 with pref_valid low and leave the table
// untouched. A beat is taken when valid is high and stall is low, on either channel.
// Pipeline: the input register takes the beat at the accept edge and the result
// register loads it from there whenever the result register is free, so a receiver
// stall between the two holds the beat in the input register.
// Throughput: one request per cycle unless stalled; the table read, compare, subtract
// and counter update for a class all sit in the one stage behind the input register.
// Receiver stall: the result register holds; the input register fills, then
// in_stall rises in the same cycle, so nothing is dropped.
// Reset: max_run returns to 2, every preference to 65535, every run counter to 0,
// both pipeline stages empty. Writing a start register reloads that preference at
// once; configure only while no request is in flight.
module dual_stack_local_pref_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lpa_pkg::lpa_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lpa_pkg::lpa_out_t               out_data,
  input  logic                            cfg_wen,
  input  logic [lpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpa_pkg::*;

  logic       s1_valid;
  lpa_in_t    s1_data;
  logic       s1_free;
  logic       out_free;
  logic       s1_fire;
  logic [RUN_W-1:0] max_run;
  lpa_req_t   req;
  lpa_cfg_t   cfg;
  lpa_out_t   result;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign s1_free  = !s1_valid || out_free;
  assign in_stall = !s1_free;

  assign req.fire  = s1_fire;
  assign req.item  = s1_data;
  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run <= MAX_RUN_RESET;
    end else if (cfg_wen && (cfg_index == REG_MAX_RUN)) begin
      max_run <= cfg_data[RUN_W-1:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
    if (s1_free && in_valid) begin
      s1_data <= in_data;
    end
  end

  lpa_pref_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cfg     (cfg),
    .max_run (max_run),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_fire) begin
      out_data <= result;
    end
  end

  a_unsupported_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pref_valid) |-> (out_data.pref_value == '0))
    else $error("unsupported class returned a nonzero preference");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input accepted while both stages are full");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_class_valid: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && ((s1_data.cand_class == CLASS_HOST) ||
                 (s1_data.cand_class == CLASS_SRFLX) ||
                 (s1_data.cand_class == CLASS_RELAY)))
    |=> (out_valid && out_data.pref_valid))
    else $error("supported class produced no valid grant");

endmodule

// ===== hdl/lpa_pref_table.sv =====
// lpa_pref_table: per class preference and run counter table with the grant logic
// depends on lpa_pkg; instantiated by dual_stack_local_pref_allocator_unit
module lpa_pref_table (
  input  logic                         clk,
  input  logic                         rst,
  input  lpa_pkg::lpa_req_t            req,
  input  lpa_pkg::lpa_cfg_t            cfg,
  input  logic [lpa_pkg::RUN_W-1:0]    max_run,
  output lpa_pkg::lpa_out_t            result
);
  import lpa_pkg::*;

  logic [PREF_W-1:0] v6_pref [NUM_CLASSES];
  logic [PREF_W-1:0] v4_pref [NUM_CLASSES];
  logic [RUN_W-1:0]  v6_run  [NUM_CLASSES];
  logic [RUN_W-1:0]  v4_run  [NUM_CLASSES];

  logic                 supported;
  logic [CLS_IDX_W-1:0] cls;
  logic                 v6_hit;
  logic                 v4_hit;
  logic [RUN_W-1:0]     v6_run_mid;
  logic [RUN_W-1:0]     v4_run_mid;
  logic [PREF_W-1:0]    v6_pref_next;
  logic [PREF_W-1:0]    v4_pref_next;
  logic [RUN_W-1:0]     v6_run_next;
  logic [RUN_W-1:0]     v4_run_next;

  logic                 cfg_start;
  logic [CFG_IDX_W-1:0] cfg_slot;
  logic [CLS_IDX_W-1:0] cfg_cls;

  assign supported = (req.item.cand_class == CLASS_HOST) ||
                     (req.item.cand_class == CLASS_SRFLX) ||
                     (req.item.cand_class == CLASS_RELAY);
  assign cls = req.item.cand_class[CLS_IDX_W-1:0] - CLS_IDX_W'(1);

  // ipv6 check first, then ipv4 on the possibly cleared counter
  always_comb begin
    v6_hit       = (v6_run[cls] >= max_run);
    v6_pref_next = v6_hit ? (v6_pref[cls] - PREF_STEP) : v6_pref[cls];
    v6_run_mid   = v6_hit ? '0 : v6_run[cls];
    v4_run_mid   = v6_hit ? '0 : v4_run[cls];
    v4_hit       = (v4_run_mid >= max_run);
    v4_pref_next = v4_hit ? (v4_pref[cls] - PREF_STEP) : v4_pref[cls];
    v6_run_next  = v4_hit ? '0 : v6_run_mid;
    v4_run_next  = v4_hit ? '0 : v4_run_mid;
    if (req.item.is_ipv6) begin
      v6_run_next = v6_run_next + RUN_W'(1);
    end else begin
      v4_run_next = v4_run_next + RUN_W'(1);
    end
  end

  always_comb begin
    result.pref_valid = supported;
    result.pref_value = '0;
    if (supported) begin
      result.pref_value = req.item.is_ipv6 ? v6_pref_next : v4_pref_next;
    end
  end

  assign cfg_start = cfg.wen && (cfg.index >= REG_HOST_V6_START) &&
                     (cfg.index <= REG_RELAY_V4_START);
  assign cfg_slot  = cfg.index - REG_HOST_V6_START;
  assign cfg_cls   = cfg_slot[CFG_IDX_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        v6_pref[i] <= PREF_RESET;
        v4_pref[i] <= PREF_RESET;
        v6_run[i]  <= '0;
        v4_run[i]  <= '0;
      end
    end else if (cfg_start) begin
      if (cfg_slot[0]) begin
        v4_pref[cfg_cls] <= cfg.data[PREF_W-1:0];
      end else begin
        v6_pref[cfg_cls] <= cfg.data[PREF_W-1:0];
      end
    end else if (req.fire && supported) begin
      v6_pref[cls] <= v6_pref_next;
      v4_pref[cls] <= v4_pref_next;
      v6_run[cls]  <= v6_run_next;
      v4_run[cls]  <= v4_run_next;
    end
  end

endmodule

// ===== tb/lpa_checker.sv =====
// lpa_checker: watches the request, grant and register ports of the local preference allocator
// keeps its own preference table and compares every grant; depends on lpa_pkg
`timescale 1ns / 1ps
module lpa_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  lpa_pkg::lpa_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  lpa_pkg::lpa_out_t               out_data,
  input  logic                            cfg_wen,
  input  logic [lpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              checked
);
  import lpa_pkg::*;

  logic [RUN_W-1:0]  run_limit;
  logic [PREF_W-1:0] pref6 [NUM_CLASSES];
  logic [PREF_W-1:0] pref4 [NUM_CLASSES];
  logic [RUN_W-1:0]  run6  [NUM_CLASSES];
  logic [RUN_W-1:0]  run4  [NUM_CLASSES];
  lpa_out_t          grant_q [$];
  int                fails = 0;
  int                seen = 0;

  function automatic lpa_out_t grant_pref(input lpa_in_t req);
    lpa_out_t res;
    int c;
    res = '0;
    case (req.cand_class)
      CLASS_HOST:  c = 0;
      CLASS_SRFLX: c = 1;
      CLASS_RELAY: c = 2;
      default:     c = -1;
    endcase
    if (c < 0) return res;
    if (run6[c] >= run_limit) begin
      pref6[c] = pref6[c] - PREF_STEP;
      run6[c] = '0;
      run4[c] = '0;
    end
    if (run4[c] >= run_limit) begin
      pref4[c] = pref4[c] - PREF_STEP;
      run4[c] = '0;
      run6[c] = '0;
    end
    res.pref_valid = 1'b1;
    if (req.is_ipv6) begin
      res.pref_value = pref6[c];
      run6[c] = run6[c] + 1'b1;
    end else begin
      res.pref_value = pref4[c];
      run4[c] = run4[c] + 1'b1;
    end
    return res;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MAX_RUN:        run_limit = val[RUN_W-1:0];
      REG_HOST_V6_START:  pref6[0] = val;
      REG_HOST_V4_START:  pref4[0] = val;
      REG_SRFLX_V6_START: pref6[1] = val;
      REG_SRFLX_V4_START: pref4[1] = val;
      REG_RELAY_V6_START: pref6[2] = val;
      REG_RELAY_V4_START: pref4[2] = val;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    lpa_out_t want;
    if (rst) begin
      run_limit = MAX_RUN_RESET;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        pref6[i] = PREF_RESET;
        pref4[i] = PREF_RESET;
        run6[i] = '0;
        run4[i] = '0;
      end
      grant_q.delete();
    end else begin
      if (cfg_wen) load_reg(cfg_index, cfg_data);
      // pop before push so a grant can never match a request taken at the same edge
      if (out_valid && !out_stall) begin
        seen++;
        if (grant_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected grant beat: pref %h valid %b",
                     out_data.pref_value, out_data.pref_valid);
        end else begin
          want = grant_q.pop_front();
          if (out_data.pref_value !== want.pref_value ||
              out_data.pref_valid !== want.pref_valid) begin
            fails++;
            if (fails <= 10)
              $display("grant mismatch: expected pref %h valid %b, got pref %h valid %b",
                       want.pref_value, want.pref_valid,
                       out_data.pref_value, out_data.pref_valid);
          end
        end
      end
      if (in_valid && !in_stall) grant_q.push_back(grant_pref(in_data));
    end
    outstanding <= grant_q.size();
    mismatches <= fails;
    checked <= seen;
  end

endmodule

// ===== tb/testbench.sv =====
// testbench: drives requests, register writes and receiver stalls into the allocator
// depends on lpa_pkg, dual_stack_local_pref_allocator_unit and lpa_checker
`timescale 1ns / 1ps
module testbench;
  import lpa_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RESET_CYCLES = 8;
  localparam int LONG_HOLD    = 60;
  localparam int SETTLE       = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;

  localparam logic [CLASS_W-1:0]   CLASS_SPARE_LO = 3'd5;
  localparam logic [CLASS_W-1:0]   CLASS_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 3'd7;

  typedef enum logic [1:0] {RX_NONE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  lpa_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  lpa_out_t              out_data;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int       mismatches;
  int       outstanding;
  int       checked;
  int       cycles = 0;
  int       sent = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  logic     last_v6 = 1'b0;
  rx_mode_t stall_mode = RX_LIGHT;
  int       hold_count = 0;
  int       holds_done = 0;

  dual_stack_local_pref_allocator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpa_checker grant_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("run stopped after %0d cycles with %0d grants still due", cycles, outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: stall pattern per phase, plus long hold-offs on request
  initial begin
    int tick;
    tick = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_count != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        case (stall_mode)
          RX_NONE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 99) < 25);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 99) < 70);
          default:   out_stall <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  function automatic lpa_in_t req_of(input logic [CLASS_W-1:0] cls, input logic v6);
    lpa_in_t r;
    r.cand_class = cls;
    r.is_ipv6 = v6;
    return r;
  endfunction

  function automatic lpa_in_t random_request();
    lpa_in_t r;
    int k;
    if ($urandom_range(0, 9) < 8) begin
      r.cand_class = CLASS_HOST + CLASS_W'($urandom_range(0, 2));
    end else begin
      k = $urandom_range(0, 4);
      r.cand_class = (k == 0) ? CLASS_NONE : CLASS_W'(int'(CLASS_PRFLX) + k - 1);
    end
    // families come in runs so the run limits are reached
    if ($urandom_range(0, 9) < 3) last_v6 = ~last_v6;
    r.is_ipv6 = last_v6;
    return r;
  endfunction

  function automatic logic [PREF_W-1:0] pick_start();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return PREF_STEP - 1'b1;
      3:       return PREF_STEP;
      default: return PREF_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic offer(input lpa_in_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid <= 1'b0;
        in_data <= req_of(CLASS_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input int p);
    logic [RUN_W-1:0]      limit;
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_IDX_W-1:0]  idx;
    case (p)
      0:       limit = '0;
      1:       limit = '1;
      2:       limit = 8'd1;
      3:       limit = 8'd3;
      4:       limit = MAX_RUN_RESET;
      default: limit = RUN_W'($urandom_range(0, 6));
    endcase
    word = CFG_DATA_W'($urandom);
    word[RUN_W-1:0] = limit;
    write_reg(REG_MAX_RUN, word);
    idx = REG_HOST_V6_START;
    repeat (NUM_CLASSES * 2) begin
      if (p == 0) word = '0;
      else if (p == 1) word = '1;
      else word = pick_start();
      write_reg(idx, word);
      idx = idx + 1'b1;
    end
    if (p == 3) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CLASS_W-1:0] code;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wen <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: runs of one family, then each class and the unsupported codes
    repeat (5) offer(req_of(CLASS_HOST, 1'b1));
    repeat (3) offer(req_of(CLASS_HOST, 1'b0));
    repeat (2) begin
      offer(req_of(CLASS_SRFLX, 1'b1));
      offer(req_of(CLASS_SRFLX, 1'b0));
    end
    repeat (3) offer(req_of(CLASS_RELAY, 1'b0));
    offer(req_of(CLASS_NONE, 1'b0));
    offer(req_of(CLASS_NONE, 1'b1));
    offer(req_of(CLASS_PRFLX, 1'b1));
    offer(req_of(CLASS_PRFLX, 1'b0));
    code = CLASS_SPARE_LO;
    repeat (CLASS_SPARE_HI - CLASS_SPARE_LO + 1) begin
      offer(req_of(code, code[0]));
      code = code + 1'b1;
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      stall_mode = rx_mode_t'(p % 4);
      gaps_on = (p != 2) && (p != 5);
      configure(p);
      // long hold-off, in phase 2 with the sender offering back to back
      if (p == 2 || p == 6) hold_count++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer(random_request());
        if (p == 4 && i == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    $display("covered %0d requests and %0d grants over %0d register settings,",
             sent, checked, PHASES + 1);
    $display("run limits from zero to full scale and start values at both ends");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
